@@ rtl/slir_pkg.sv @@
// Shared types and constants for the static list insert/remove core.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package slir_pkg;

    // Field widths fixed by the word formats.
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int OP_W         = 1;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 8;
    localparam int CAPACITY_DEF = 16;

    // Operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the accepted request and restart the scan
        logic scan_en;  // step the search-and-shift pass
        logic commit;   // update the count and load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every held entry has been read and processed
    } stat_t;

endpackage

@@ rtl/slir_ctrl.sv @@
// Controller state machine for the static list core.
// Sequences accept, search-and-shift pass and result hand-off.
// Depends on slir_pkg.
module slir_ctrl
    import slir_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic [OP_W-1:0] s_op,
    input  logic            m_tready,
    input  stat_t           stat_i,
    output logic            s_tready,
    output logic            m_tvalid,
    output cmd_t            cmd_o
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign accept   = s_tready && s_tvalid;

    // Commands follow the current state.
    always_comb begin
        cmd_o.load    = accept;
        cmd_o.scan_en = (state_reg == S_SCAN);
        cmd_o.commit  = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);
    end

    // Next state and output valid.
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = (s_op == OP_REMOVE) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (stat_i.scan_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (cmd_o.commit) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ rtl/slir_dpath.sv @@
// Datapath for the static list core: entry memory, fill count,
// search-and-shift pass and the result register. Depends on slir_pkg.
module slir_dpath
    import slir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd_i,
    input  logic [OP_W-1:0]      s_op,
    input  logic [DATA_W-1:0]    s_value,
    output stat_t                stat_o,
    output logic [M_TDATA_W-1:0] m_result
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Entry memory: one write port, one registered read port.
    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rdata_reg;

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [CW-1:0]     ptr_reg;
    logic [AW-1:0]     pidx_reg;
    logic              pv_reg;
    logic              found_reg;

    logic              rd_en;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    status_t           status_next;

    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                empty_reg;

    assign rd_en            = cmd_i.scan_en && (ptr_reg < fill_reg);
    assign stat_o.scan_done = (ptr_reg == fill_reg) && !pv_reg;
    assign m_result         = {empty_reg, count_reg, status_reg};

    // Outcome of the request and the count after it.
    always_comb begin
        fill_next   = fill_reg;
        status_next = STAT_DONE;
        if (op_reg == OP_INSERT) begin
            if (fill_reg == CAP_CNT) begin
                status_next = STAT_FULL;
            end else begin
                fill_next = fill_reg + 1'b1;
            end
        end else begin
            if (fill_reg == '0) begin
                status_next = STAT_EMPTY;
            end else if (found_reg) begin
                fill_next = fill_reg - 1'b1;
            end else begin
                status_next = STAT_NOT_FOUND;
            end
        end
    end

    // Write port: shift an entry down during the pass, or append on commit.
    always_comb begin
        we    = 1'b0;
        waddr = fill_reg[AW-1:0];
        wdata = value_reg;
        if (cmd_i.scan_en && pv_reg && found_reg) begin
            we    = 1'b1;
            waddr = pidx_reg - 1'b1;
            wdata = rdata_reg;
        end else if (cmd_i.commit && (op_reg == OP_INSERT) && (fill_reg != CAP_CNT)) begin
            we = 1'b1;
        end
    end

    // Memory array.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    // Request capture and result payload.
    always_ff @(posedge aclk) begin
        if (cmd_i.load) begin
            op_reg    <= s_op;
            value_reg <= s_value;
        end
        if (rd_en) begin
            pidx_reg <= ptr_reg[AW-1:0];
        end
        if (cmd_i.commit) begin
            status_reg <= status_next;
            count_reg  <= COUNT_W'(fill_next);
            empty_reg  <= (fill_next == '0);
        end
    end

    // Fill count, scan pointer and match tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            ptr_reg   <= '0;
            pv_reg    <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            if (cmd_i.load) begin
                ptr_reg   <= '0;
                pv_reg    <= 1'b0;
                found_reg <= 1'b0;
            end else if (cmd_i.scan_en) begin
                pv_reg <= rd_en;
                if (rd_en) begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
                // The first match switches the pass from searching to shifting.
                if (pv_reg && !found_reg && (rdata_reg == value_reg)) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd_i.commit) begin
                fill_reg <= fill_next;
            end
        end
    end

endmodule

@@ rtl/static_list_insert_remove_core.sv @@
// Fixed-capacity list of signed 32-bit values with insert and remove.
// Request words arrive on the s_ channel: s_tuser carries the operation
// (insert at the end, or remove the first entry equal to the value) and
// s_tdata the value. Every request returns one result word on the m_
// channel with the status, the count after the request and an empty flag.
// An insert goes from acceptance straight to its last step. A remove
// reads every held entry once through the memory's single read port, moving
// each entry after the match down by one on the same pass, before its last
// step. The next request is accepted in the cycle after the result has been
// loaded.
// The result sits in an output register: a new request is accepted while it
// waits, and if the receiver stalls long enough the finished request holds
// in its last step until the register frees up.
// Reset empties the list and drops any pending result; entry storage is not
// cleared, since only written entries are ever read.
// Depends on slir_pkg, slir_ctrl and slir_dpath.
module static_list_insert_remove_core
    import slir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [OP_W-1:0]      s_tuser,   // [0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [1:0] status, [6:2] count, [7] is_empty
);

    cmd_t  cmd;
    stat_t stat;

    slir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .m_tready (m_tready),
        .stat_i   (stat),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd_o    (cmd)
    );

    slir_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_i    (cmd),
        .s_op     (s_tuser),
        .s_value  (s_tdata[DATA_W-1:0]),
        .stat_o   (stat),
        .m_result (m_tdata)
    );

endmodule

@@ rtl/slir_chk.sv @@
// Port-level checker for the static list core, bound to the top level.
// Depends on slir_pkg and static_list_insert_remove_core.
module slir_chk
    import slir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic SMALL_CAP = (CAPACITY < 32);
    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

    logic                empty_flag;
    logic [COUNT_W-1:0]  count_f;
    logic [STATUS_W-1:0] status_f;

    assign status_f   = m_tdata[1:0];
    assign count_f    = m_tdata[6:2];
    assign empty_flag = m_tdata[7];

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Reset drops any pending result.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // While the capacity is below 32, the empty flag agrees with the count.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && SMALL_CAP |-> (empty_flag == (count_f == '0)))
        else $error("empty flag disagrees with count");

    // A full report shows a list at capacity.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status_f == STAT_FULL) |-> (count_f == CAP_CNT) && !empty_flag)
        else $error("full status with count below capacity");

    // An empty report shows an empty list.
    a_emp_st: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status_f == STAT_EMPTY) |-> empty_flag)
        else $error("empty status on a non-empty list");

endmodule

bind static_list_insert_remove_core slir_chk #(.CAPACITY(CAPACITY)) u_slir_chk (.*);

@@ sim/static_list_insert_remove_core_tb.sv @@
// Self-checking testbench for static_list_insert_remove_core: inserts and removes are streamed in,
// and every result word is checked against a behavioral model of the list kept in the testbench.
// Depends on slir_pkg and the RTL of the core; needs no files or arguments.
module static_list_insert_remove_core_tb;
    import slir_pkg::*;

    localparam int LIST_DEPTH   = CAPACITY_DEF;
    localparam int POOL_N       = 6;
    localparam int ITEMS_PHASE  = 575;
    localparam int PRESSURE_AT  = 1400;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } list_request_t;

    typedef struct {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } list_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = OP_INSERT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Words waiting to be sent and results waiting to arrive.
    list_request_t pending_requests[$];
    list_result_t  expected_results[$];

    // Model of the list contents.
    logic [DATA_W-1:0] list_entries[LIST_DEPTH];
    int                list_fill = 0;

    // Pool of values that removes usually look for, so that they hit held entries.
    logic [DATA_W-1:0] value_pool[POOL_N];

    int phase             = 0;
    int accepted_requests = 0;
    int checked_results   = 0;
    int errors            = 0;
    int hold_left         = 0;
    bit hold_done         = 1'b0;
    int status_seen[4]    = '{0, 0, 0, 0};
    int inserts_sent      = 0;
    int removes_sent      = 0;

    static_list_insert_remove_core #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [31:0] value
        .s_tuser (s_tuser),   // [0] operation
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)    // [1:0] status, [6:2] count, [7] is_empty
    );

    always #5 aclk = ~aclk;

    // Applies one request to the list model and returns the result word it must produce.
    task automatic apply_list_request(input list_request_t req, output list_result_t res);
        int pos;
        pos = 0;
        if (req.op == OP_INSERT) begin
            inserts_sent++;
            if (list_fill >= LIST_DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                list_entries[list_fill] = req.value;
                list_fill++;
                res.status = STAT_DONE;
            end
        end else begin
            removes_sent++;
            if (list_fill == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                while (pos < list_fill && list_entries[pos] != req.value)
                    pos++;
                if (pos >= list_fill) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    // Close the gap left by the first matching entry.
                    for (int i = pos; i + 1 < list_fill; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_fill--;
                    res.status = STAT_DONE;
                end
            end
        end
        res.count    = list_fill[COUNT_W-1:0];
        res.is_empty = (list_fill == 0);
        status_seen[res.status]++;
    endtask

    task automatic add_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        list_request_t req;
        req.op    = op;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return value_pool[$urandom_range(POOL_N - 1)];
        if (r < 80)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Random traffic in runs that lean toward filling or draining the list, or stay even, so
    // that both the full and the empty ends are reached again and again.
    task automatic add_random_phase(input int n);
        int made;
        int run_len;
        int insert_pct;
        made = 0;
        while (made < n) begin
            case ($urandom_range(2))
                0:       insert_pct = 80;
                1:       insert_pct = 25;
                default: insert_pct = 50;
            endcase
            run_len = $urandom_range(12, 40);
            for (int k = 0; k < POOL_N; k++)
                value_pool[k] = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom;
            for (int k = 0; k < run_len && made < n; k++) begin
                if ($urandom_range(99) < insert_pct)
                    add_request(OP_INSERT, pick_value());
                else
                    add_request(OP_REMOVE, pick_value());
                made++;
            end
        end
    endtask

    // Request driver: holds the word until it is taken, then offers the next one
    // unless this cycle is chosen to idle.
    always @(posedge aclk) begin : drive_requests
        list_request_t req;
        list_result_t  res;
        int            send_idle_pct;
        send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 85 : 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                req = pending_requests.pop_front();
                apply_list_request(req, res);
                expected_results.push_back(res);
                accepted_requests++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_requests[0].value;
                s_tuser  <= pending_requests[0].op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver ready: random stalls, plus one long hold-off that backs the
    // core up until it stops taking requests.
    always @(posedge aclk) begin : drive_ready
        int recv_idle_pct;
        recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 35 : 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && accepted_requests >= PRESSURE_AT) begin
            m_tready  <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result monitor: compares each accepted word with the oldest expected result.
    always @(posedge aclk) begin : check_results
        list_result_t exp_res;
        list_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status   = status_t'(m_tdata[1:0]);
            got.count    = m_tdata[6:2];
            got.is_empty = m_tdata[7];
            if (expected_results.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("ERROR: unexpected result word status=%0d count=%0d empty=%0b",
                             got.status, got.count, got.is_empty);
                errors++;
            end else begin
                exp_res = expected_results.pop_front();
                checked_results++;
                if (got.status !== exp_res.status || got.count !== exp_res.count ||
                    got.is_empty !== exp_res.is_empty) begin
                    if (errors < MAX_REPORTS)
                        $display("ERROR: result %0d: expected status=%0d count=%0d empty=%0b,",
                                 checked_results, exp_res.status, exp_res.count,
                                 exp_res.is_empty, " got status=%0d count=%0d empty=%0b",
                                 got.status, got.count, got.is_empty);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("static_list_insert_remove_core_tb: done, errors");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: remove from an empty list.
        add_request(OP_REMOVE, 32'h0000_0001);
        // Extreme values and a duplicate pair.
        add_request(OP_INSERT, 32'h8000_0000);
        add_request(OP_INSERT, 32'h7FFF_FFFF);
        add_request(OP_INSERT, 32'h0000_0005);
        add_request(OP_INSERT, 32'h0000_0005);
        add_request(OP_INSERT, 32'hFFFF_FFFF);
        add_request(OP_INSERT, 32'h0000_0000);
        // Only the first of the duplicates goes; then a search that misses.
        add_request(OP_REMOVE, 32'h0000_0005);
        add_request(OP_REMOVE, 32'h0001_2345);
        // Fill up to capacity, then insert once more into the full list.
        for (int k = 0; k < LIST_DEPTH - 5; k++)
            add_request(OP_INSERT, 32'hA5A5_0000 + k);
        add_request(OP_INSERT, 32'h5A5A_5A5A);
        // Remove the front entry, the last entry, and one from the middle.
        add_request(OP_REMOVE, 32'h8000_0000);
        add_request(OP_REMOVE, 32'hA5A5_0000 + LIST_DEPTH - 6);
        add_request(OP_REMOVE, 32'hFFFF_FFFF);

        for (int p = 0; p < 3; p++) begin
            @(negedge aclk);
            phase = p;
            add_random_phase(ITEMS_PHASE);
            while (pending_requests.size() > 0)
                @(negedge aclk);
        end

        while (expected_results.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_results.size() != 0)
            errors++;

        $display("Checked %0d result words from %0d inserts and %0d removes.",
                 checked_results, inserts_sent, removes_sent);
        $display("Statuses seen: done %0d, full %0d, empty %0d, not found %0d; %0d errors.",
                 status_seen[STAT_DONE], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
                 status_seen[STAT_NOT_FOUND], errors);
        if (errors == 0)
            $display("static_list_insert_remove_core_tb: done, clean");
        else
            $display("static_list_insert_remove_core_tb: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/slir_pkg.sv
rtl/slir_ctrl.sv
rtl/slir_dpath.sv
rtl/static_list_insert_remove_core.sv
rtl/slir_chk.sv
sim/static_list_insert_remove_core_tb.sv
